// File: src/mrf_pkg.sv
`default_nettype none

package mrf_pkg;

  localparam int unsigned CmdBytes = 7;
  localparam int unsigned LenW     = 3;
  localparam int unsigned IdxW     = 4;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  localparam logic [7:0] FcReadCoils    = 8'd1;
  localparam logic [7:0] FcWriteSingle  = 8'd6;
  localparam logic [7:0] FcWriteCoils   = 8'd15;
  localparam logic [7:0] FcWriteRegs    = 8'd16;

  localparam logic ModeHeader = 1'b0;
  localparam logic ModeData   = 1'b1;

  typedef struct packed {
    logic                          start;
    logic [CmdBytes-1:0][7:0]      data;
    logic [LenW-1:0]               len;
    logic                          crc;
  } cmd_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: src/mrf_front.sv
`default_nettype none

module mrf_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_fire_i,
  input  wire logic              mode_i,
  input  wire logic [7:0]        slave_id_i,
  input  wire logic [7:0]        func_code_i,
  input  wire logic [15:0]       start_addr_i,
  input  wire logic [15:0]       quantity_i,
  input  wire logic [7:0]        payload_len_i,
  input  wire logic [15:0]       data_value_i,
  output logic                   cmd_valid_o,
  output mrf_pkg::cmd_t          cmd_o
);
  import mrf_pkg::*;

  logic        open_q, open_d;
  logic        coils_q, coils_d;
  logic [15:0] left_q, left_d;
  logic [7:0]  acc_q, acc_d;
  logic [2:0]  bidx_q, bidx_d;

  logic        single, multi, done, full;
  logic [7:0]  acc_new;
  logic [2:0]  bidx_new;
  logic [15:0] left_new;
  cmd_t        cmd;
  logic        has_cmd;

  always_comb begin
    single   = (func_code_i >= FcReadCoils) && (func_code_i <= FcWriteSingle);
    multi    = (func_code_i == FcWriteCoils) || (func_code_i == FcWriteRegs);
    acc_new  = acc_q | ((data_value_i != 16'd0) ? (8'd1 << bidx_q) : 8'd0);
    bidx_new = bidx_q + 3'd1;
    full     = (bidx_new == 3'd0);
    left_new = left_q - 16'd1;
    done     = (left_new == 16'd0);

    open_d  = open_q;
    coils_d = coils_q;
    left_d  = left_q;
    acc_d   = acc_q;
    bidx_d  = bidx_q;

    cmd       = '0;
    has_cmd   = 1'b0;

    if (mode_i == ModeHeader) begin
      open_d = 1'b0;
      acc_d  = 8'd0;
      bidx_d = 3'd0;
      left_d = 16'd0;
      cmd.start   = 1'b1;
      cmd.data[0] = slave_id_i;
      cmd.data[1] = func_code_i;
      cmd.data[2] = start_addr_i[15:8];
      cmd.data[3] = start_addr_i[7:0];
      cmd.data[4] = quantity_i[15:8];
      cmd.data[5] = quantity_i[7:0];
      cmd.data[6] = payload_len_i;
      cmd.len     = single ? LenW'(6) : LenW'(7);
      cmd.crc     = single || (quantity_i == 16'd0);
      has_cmd     = single || multi;
      if (multi) begin
        coils_d = (func_code_i == FcWriteCoils);
        if (quantity_i != 16'd0) begin
          open_d = 1'b1;
          left_d = quantity_i;
        end
      end
    end else if (open_q) begin
      left_d  = left_new;
      open_d  = !done;
      cmd.crc = done;
      if (coils_q) begin
        cmd.data[0] = acc_new;
        cmd.len     = (full || (done && (bidx_new != 3'd0))) ? LenW'(1) : LenW'(0);
        acc_d       = (full || done) ? 8'd0 : acc_new;
        bidx_d      = done ? 3'd0 : bidx_new;
      end else begin
        cmd.data[0] = data_value_i[15:8];
        cmd.data[1] = data_value_i[7:0];
        cmd.len     = LenW'(2);
      end
      has_cmd = (cmd.len != LenW'(0)) || done;
    end
  end

  assign cmd_valid_o = in_fire_i && has_cmd;
  assign cmd_o       = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= 1'b0;
      coils_q <= 1'b0;
      left_q  <= 16'd0;
      acc_q   <= 8'd0;
      bidx_q  <= 3'd0;
    end else if (in_fire_i) begin
      open_q  <= open_d;
      coils_q <= coils_d;
      left_q  <= left_d;
      acc_q   <= acc_d;
      bidx_q  <= bidx_d;
    end
  end

endmodule

`default_nettype wire

// File: src/mrf_cmd_fifo.sv
`default_nettype none

module mrf_cmd_fifo #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire mrf_pkg::cmd_t     push_cmd_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   empty_o,
  output mrf_pkg::cmd_t          pop_cmd_o
);
  import mrf_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o    = (cnt_q == CntW'(QueueDepth));
  assign empty_o   = (cnt_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign pop_cmd_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QueueDepth))
    else $error("Command queue count exceeds its depth.");
  a_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && full_o && !pop_i) |=> full_o)
    else $error("Command queue left the full state without a pop.");
  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty_o && !push_i) |=> empty_o)
    else $error("Command queue filled without a push.");
`endif

endmodule

`default_nettype wire

// File: src/mrf_back.sv
`default_nettype none

module mrf_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cmd_empty_i,
  input  wire mrf_pkg::cmd_t     cmd_i,
  output logic                   cmd_pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [7:0]             out_byte_o,
  output logic                   last_o
);
  import mrf_pkg::*;

  cmd_t            cmd_q, cmd_d;
  logic            busy_q, busy_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [15:0]     crc_q, crc_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_byte_q, out_byte_d;
  logic            last_q, last_d;

  logic            adv, emit, finish, load, is_data, is_crc_lo;
  logic [IdxW-1:0] total;
  logic [7:0]      sel_byte;

  always_comb begin
    adv       = !out_valid_q || out_ready_i;
    emit      = busy_q && adv;
    total     = IdxW'(cmd_q.len) + (cmd_q.crc ? IdxW'(2) : IdxW'(0));
    finish    = emit && (idx_q == total - IdxW'(1));
    load      = (!busy_q || finish) && !cmd_empty_i;
    is_data   = idx_q < IdxW'(cmd_q.len);
    is_crc_lo = idx_q == IdxW'(cmd_q.len);
    sel_byte  = cmd_q.data[idx_q[LenW-1:0]];

    cmd_d       = cmd_q;
    busy_d      = busy_q;
    idx_d       = idx_q;
    crc_d       = crc_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    last_d      = last_q;

    if (emit) begin
      out_valid_d = 1'b1;
      idx_d       = idx_q + IdxW'(1);
      if (is_data) begin
        out_byte_d = sel_byte;
        last_d     = 1'b0;
        crc_d      = crc_byte(crc_q, sel_byte);
      end else if (is_crc_lo) begin
        out_byte_d = crc_q[7:0];
        last_d     = 1'b0;
      end else begin
        out_byte_d = crc_q[15:8];
        last_d     = 1'b1;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (finish) begin
      busy_d = 1'b0;
    end
    if (load) begin
      busy_d = 1'b1;
      cmd_d  = cmd_i;
      idx_d  = '0;
      if (cmd_i.start) begin
        crc_d = CrcInit;
      end
    end
  end

  assign cmd_pop_o   = load;
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = last_q;

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    out_byte_q <= out_byte_d;
    last_q     <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      crc_q       <= CrcInit;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (idx_q < total))
    else $error("Byte index ran past the end of the current item.");
  a_load_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (busy_q && (idx_q == '0)))
    else $error("A loaded item did not start at its first byte.");
  a_crc_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (finish && cmd_q.crc) |=> (out_valid_o && last_o))
    else $error("A frame closed without flagging its final CRC byte.");
`endif

endmodule

`default_nettype wire

// File: src/modbus_rtu_request_framer_core.sv
// Channel  Handshake                  Payload
// input    in_valid_i / in_ready_o    mode, slave_id, func_code, start_addr, quantity,
//                                     payload_len, data_value
// output   out_valid_o / out_ready_i  out_byte, last
//
// The output register sends one byte per cycle while out_ready_i allows it, so a short header yields eight bytes,
// a multi-write header seven (nine with an empty payload) and a word element two
// (four when it closes the frame).
// The front end takes an item whenever the command queue has room.
// Reset clears the frame state, the queue and the output valid flag; CRC starts at 0xFFFF.
// A stalled output holds its byte while the front end keeps filling the queue.
`default_nettype none

module modbus_rtu_request_framer_core #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        mode_i,
  input  wire logic [7:0]  slave_id_i,
  input  wire logic [7:0]  func_code_i,
  input  wire logic [15:0] start_addr_i,
  input  wire logic [15:0] quantity_i,
  input  wire logic [7:0]  payload_len_i,
  input  wire logic [15:0] data_value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             last_o
);
  import mrf_pkg::*;

  logic in_fire, cmd_valid, q_full, q_empty, q_pop;
  cmd_t cmd_push, cmd_head;

  assign in_ready_o = !q_full;
  assign in_fire    = in_valid_i && in_ready_o;

  mrf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_fire_i     (in_fire),
    .mode_i        (mode_i),
    .slave_id_i    (slave_id_i),
    .func_code_i   (func_code_i),
    .start_addr_i  (start_addr_i),
    .quantity_i    (quantity_i),
    .payload_len_i (payload_len_i),
    .data_value_i  (data_value_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd_push)
  );

  mrf_cmd_fifo #(
    .QueueDepth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (cmd_valid),
    .push_cmd_i (cmd_push),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .pop_cmd_o  (cmd_head)
  );

  mrf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (q_empty),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

// File: bench/modbus_rtu_request_framer_core_tb.sv
`timescale 1ns / 1ps

import mrf_pkg::*;

typedef struct packed {
  logic        mode;
  logic [7:0]  slave_id;
  logic [7:0]  func_code;
  logic [15:0] start_addr;
  logic [15:0] quantity;
  logic [7:0]  payload_len;
  logic [15:0] data_value;
} request_t;

typedef struct packed {
  logic [7:0] value;
  logic       last;
} wire_byte_t;

class rtu_frame_scoreboard;
  wire_byte_t  wire_q[$];
  int unsigned mismatches;
  logic [15:0] crc;
  logic        frame_open;
  logic        coils;
  logic [15:0] elems_left;
  logic [7:0]  coil_byte;
  logic [2:0]  coil_idx;

  function new();
    mismatches = 0;
    crc        = CrcInit;
    frame_open = 1'b0;
    coils      = 1'b0;
    elems_left = '0;
    coil_byte  = '0;
    coil_idx   = '0;
  endfunction

  function void emit(logic [7:0] b);
    crc = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      crc = crc[0] ? ((crc >> 1) ^ CrcPoly) : (crc >> 1);
    end
    wire_q.push_back({b, 1'b0});
  endfunction

  function void emit_crc();
    wire_q.push_back({crc[7:0], 1'b0});
    wire_q.push_back({crc[15:8], 1'b1});
    frame_open = 1'b0;
    crc        = CrcInit;
  endfunction

  // Returns one unless the item is simply ignored by the block.
  function bit note_request(request_t r);
    logic single;
    logic multi;
    single = (r.func_code >= FcReadCoils) && (r.func_code <= FcWriteSingle);
    multi  = (r.func_code == FcWriteCoils) || (r.func_code == FcWriteRegs);
    if (r.mode == ModeHeader) begin
      frame_open = 1'b0;
      coil_byte  = '0;
      coil_idx   = '0;
      elems_left = '0;
      if (!single && !multi) return 1'b0;
      crc = CrcInit;
      emit(r.slave_id);
      emit(r.func_code);
      emit(r.start_addr[15:8]);
      emit(r.start_addr[7:0]);
      emit(r.quantity[15:8]);
      emit(r.quantity[7:0]);
      if (single) begin
        emit_crc();
        return 1'b1;
      end
      emit(r.payload_len);
      coils = (r.func_code == FcWriteCoils);
      if (r.quantity == 0) begin
        emit_crc();
        return 1'b1;
      end
      elems_left = r.quantity;
      frame_open = 1'b1;
      return 1'b1;
    end
    if (!frame_open) return 1'b0;
    if (coils) begin
      if (r.data_value != 0) coil_byte[coil_idx] = 1'b1;
      coil_idx = coil_idx + 3'd1;
      if (coil_idx == 0) begin
        emit(coil_byte);
        coil_byte = '0;
      end
    end else begin
      emit(r.data_value[15:8]);
      emit(r.data_value[7:0]);
    end
    elems_left = elems_left - 16'd1;
    if (elems_left == 0) begin
      if (coils && coil_idx != 0) begin
        emit(coil_byte);
        coil_byte = '0;
        coil_idx  = '0;
      end
      emit_crc();
    end
    return 1'b1;
  endfunction

  function void check_wire_byte(logic [7:0] value, logic last);
    wire_byte_t exp_byte;
    if (wire_q.size() == 0) begin
      $error("unexpected byte: out_byte actual %02h, last actual %0b", value, last);
      mismatches++;
      return;
    end
    exp_byte = wire_q.pop_front();
    if (value !== exp_byte.value) begin
      $error("out_byte mismatch: expected %02h, actual %02h", exp_byte.value, value);
      mismatches++;
    end
    if (last !== exp_byte.last) begin
      $error("last mismatch: expected %0b, actual %0b", exp_byte.last, last);
      mismatches++;
    end
  endfunction
endclass

module modbus_rtu_request_framer_core_tb;

  localparam int unsigned StallLimit = 5000;
  localparam int unsigned RandomItems = 320;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready_o;
  logic        mode;
  logic [7:0]  slave_id;
  logic [7:0]  func_code;
  logic [15:0] start_addr;
  logic [15:0] quantity;
  logic [7:0]  payload_len;
  logic [15:0] data_value;
  logic        out_valid_o;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte_o;
  logic        last_o;

  rtu_frame_scoreboard sb = new();

  int unsigned burst_left;
  int unsigned useful_items;
  int unsigned quiet_cycles = 0;
  int unsigned rx_tick = 0;
  int unsigned rx_style = 0;

  modbus_rtu_request_framer_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode),
    .slave_id_i    (slave_id),
    .func_code_i   (func_code),
    .start_addr_i  (start_addr),
    .quantity_i    (quantity),
    .payload_len_i (payload_len),
    .data_value_i  (data_value),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .out_byte_o    (out_byte_o),
    .last_o        (last_o)
  );

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic request_t random_req();
    request_t r;
    r.mode        = 1'($urandom_range(0, 1));
    r.slave_id    = 8'($urandom);
    r.func_code   = 8'($urandom);
    r.start_addr  = 16'($urandom);
    r.quantity    = 16'($urandom);
    r.payload_len = 8'($urandom);
    r.data_value  = 16'($urandom);
    return r;
  endfunction

  function automatic request_t hdr(logic [7:0] fc, logic [15:0] qty);
    request_t r;
    r           = random_req();
    r.mode      = ModeHeader;
    r.func_code = fc;
    r.quantity  = qty;
    return r;
  endfunction

  function automatic request_t dat(logic [15:0] dv);
    request_t r;
    r            = random_req();
    r.mode       = ModeData;
    r.data_value = dv;
    return r;
  endfunction

  function automatic logic [7:0] unknown_code();
    logic [7:0] fc;
    fc = 8'($urandom);
    while ((fc >= FcReadCoils && fc <= FcWriteSingle) || fc == FcWriteCoils ||
           fc == FcWriteRegs) begin
      fc = 8'($urandom);
    end
    return fc;
  endfunction

  function automatic logic [15:0] coil_value();
    return ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'($urandom_range(1, 65535));
  endfunction

  task automatic send_req(request_t r);
    int unsigned gap;
    @(negedge clk_i);
    mode        = r.mode;
    slave_id    = r.slave_id;
    func_code   = r.func_code;
    start_addr  = r.start_addr;
    quantity    = r.quantity;
    payload_len = r.payload_len;
    data_value  = r.data_value;
    in_valid    = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    if (sb.note_request(r)) useful_items++;
    burst_left--;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, 15);
      burst_left = $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid = 1'b0;
      end
    end
  endtask

  task automatic drain_wait();
    @(negedge clk_i);
    in_valid = 1'b0;
    while (sb.wire_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_multi(logic [7:0] fc, logic [15:0] qty, logic [7:0] bc,
                            int unsigned n_elems);
    request_t r;
    r             = hdr(fc, qty);
    r.payload_len = bc;
    send_req(r);
    for (int unsigned i = 0; i < n_elems; i++) begin
      send_req(dat((fc == FcWriteCoils) ? coil_value() : 16'($urandom)));
    end
  endtask

  // The receiver switches at random among three stall styles.
  always @(negedge clk_i) begin
    rx_tick++;
    if (rx_tick % 300 == 0) rx_style = $urandom_range(0, 2);
    case (rx_style)
      0: begin
        out_ready = 1'b1;
      end
      1: begin
        out_ready = ($urandom_range(0, 3) != 0);
      end
      default: begin
        out_ready = (rx_tick % 8 == 5) || ($urandom_range(0, 5) == 0);
      end
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) sb.check_wire_byte(out_byte_o, last_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    request_t    r;
    int unsigned pick;
    int unsigned qty;
    bit          drained_mid;
    logic [7:0]  fc;
    logic [7:0]  bc;

    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    mode         = ModeHeader;
    slave_id     = '0;
    func_code    = '0;
    start_addr   = '0;
    quantity     = '0;
    payload_len  = '0;
    data_value   = '0;
    useful_items = 0;
    drained_mid  = 1'b0;
    burst_left   = $urandom_range(1, 12);
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int k = 0; k <= FcWriteSingle - FcReadCoils; k++) begin
      r = hdr(8'(FcReadCoils + k), 16'($urandom));
      if (k == 0) begin
        r.slave_id    = 8'h00;
        r.start_addr  = 16'h0000;
        r.quantity    = 16'h0000;
        r.payload_len = 8'h00;
        r.data_value  = 16'h0000;
      end else if (k == FcWriteSingle - FcReadCoils) begin
        r.slave_id    = 8'hFF;
        r.start_addr  = 16'hFFFF;
        r.quantity    = 16'hFFFF;
        r.payload_len = 8'hFF;
        r.data_value  = 16'hFFFF;
      end
      send_req(r);
    end
    send_req(hdr(8'h00, 16'($urandom)));
    send_req(dat(16'hFFFF));
    send_req(hdr(FcWriteCoils, 16'h0000));
    send_req(hdr(FcWriteRegs, 16'h0000));
    r             = hdr(FcWriteCoils, 16'd9);
    r.payload_len = 8'h07;
    send_req(r);
    send_req(dat(16'h0001));
    send_req(dat(16'h0000));
    send_req(dat(16'hFFFF));
    send_req(dat(16'h8000));
    send_req(dat(16'h0000));
    send_req(dat(16'h0000));
    send_req(dat(16'h0001));
    send_req(dat(16'h0002));
    send_req(dat(16'hFFFF));
    r             = hdr(FcWriteRegs, 16'd2);
    r.payload_len = 8'd4;
    send_req(r);
    send_req(dat(16'hFFFF));
    send_req(dat(16'h0000));
    send_req(hdr(FcWriteRegs, 16'd3));
    send_req(dat(16'($urandom)));
    send_req(hdr(8'(FcReadCoils + 2), 16'($urandom)));
    send_req(hdr(FcWriteCoils, 16'd5));
    send_req(dat(16'h0001));
    send_req(hdr(8'hFF, 16'($urandom)));
    drain_wait();

    useful_items = 0;
    while (useful_items < RandomItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        // A complete multi-write frame with random content.
        fc  = ($urandom_range(0, 1) == 0) ? FcWriteCoils : FcWriteRegs;
        qty = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
        if ($urandom_range(0, 4) == 0) begin
          bc = 8'($urandom);
        end else begin
          bc = (fc == FcWriteCoils) ? 8'((qty + 7) / 8) : 8'(2 * qty);
        end
        send_multi(fc, 16'(qty), bc, qty);
      end else if (pick < 75) begin
        send_req(hdr(8'($urandom_range(FcReadCoils, FcWriteSingle)), 16'($urandom)));
      end else if (pick < 88) begin
        // A frame that is cut short by whatever follows it.
        fc  = ($urandom_range(0, 1) == 0) ? FcWriteCoils : FcWriteRegs;
        qty = $urandom_range(6, 65535);
        send_multi(fc, 16'(qty), 8'($urandom), $urandom_range(0, 5));
      end else if ($urandom_range(0, 1) == 0) begin
        send_req(hdr(unknown_code(), 16'($urandom)));
      end else begin
        send_req(dat(16'($urandom)));
      end
      if (!drained_mid && useful_items >= RandomItems / 2) begin
        drained_mid = 1'b1;
        drain_wait();
      end
    end

    drain_wait();
    repeat (40) @(posedge clk_i);
    if (sb.wire_q.size() != 0) begin
      $error("%0d expected bytes never arrived", sb.wire_q.size());
      sb.mismatches++;
    end
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
